// File: rtl/impp_pkg.sv
// ----------------------------------------------------------------------------
// impp_pkg - shared types and constants of the move profile planner
// word layouts, register indexes, phase codes and datapath widths
// ----------------------------------------------------------------------------
`default_nettype none

package impp_pkg;

    // field widths
    localparam int COUNT_W    = 16;
    localparam int POS_W      = 32;
    localparam int PHASE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // shared divider: numerator covers rate times frame offset, divisor the 2*run + ramp frame sum
    localparam int DIV_NUM_W  = 57;
    localparam int DIV_DEN_W  = 17;

    // accel and decel rates are held in steps per frame per frame times this scale
    localparam int MILLI      = 1000;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADIN_COUNT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DECEL_COUNT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LEADOUT_COUNT = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_START_POS     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_END_POS       = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SHUTTER_AXIS  = 3'd7;

    // request kinds
    localparam logic REQ_PLAN = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // phase codes of a result word
    localparam logic [PHASE_W-1:0] PH_LEADIN  = 3'd0;
    localparam logic [PHASE_W-1:0] PH_ACCEL   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RUN     = 3'd2;
    localparam logic [PHASE_W-1:0] PH_DECEL   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_LEADOUT = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SHUTTER = 3'd5;
    localparam logic [PHASE_W-1:0] PH_PLAN    = 3'd6;

    typedef struct packed {
        logic                    req_type;
        logic [COUNT_W-1:0]      step_index;
        logic signed [POS_W-1:0] current_position;
    } in_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0] move_steps;
        logic [PHASE_W-1:0]      phase;
        logic                    clamped;
    } out_word_t;

endpackage

`default_nettype wire

// File: rtl/impp_div.sv
// ----------------------------------------------------------------------------
// impp_div - bit-serial unsigned divider
// restoring division, one quotient bit per cycle, quotient valid with done
// ----------------------------------------------------------------------------
`default_nettype none

module impp_div
    import impp_pkg::*;
#(
    parameter int NUM_W = DIV_NUM_W,
    parameter int DEN_W = DIV_DEN_W
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              go,
    input  wire [NUM_W-1:0]  num,
    input  wire [DEN_W-1:0]  den,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] nq_reg, nq_next;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, nq_reg[NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        fits      = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        nq_next   = nq_reg;
        if (go) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W);
            rem_next  = '0;
            den_next  = den;
            nq_next   = num;
        end else if (busy_reg) begin
            // numerator bits leave at the top, quotient bits enter at the bottom
            rem_next = fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_next  = {nq_reg[NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            nq_reg   <= nq_next;
        end
    end

    assign done = done_reg;
    assign quot = nq_reg;

endmodule

`default_nettype wire

// File: rtl/interval_move_profile_planner_core.sv
// ----------------------------------------------------------------------------
// interval_move_profile_planner_core - one axis of a shoot-move-shoot planner
// A plan word (req_type 0) takes the lead-in, accel, decel and lead-out frame
// counts from the registers, trims them to fit image_count-1 frame gaps and
// works out the run rate and the accel and decel rates of a trapezoidal step
// profile; it answers with phase 6 and zero steps. A move word (req_type 1)
// names the frame just exposed and the present position, and is answered with
// the steps for the next gap, cut so the axis stops at end_position, or with
// end minus current in shutter-axis mode. One word is worked on at a time; a
// new word is taken while the previous result still waits at the output. A
// plan runs a bit-by-bit search for the trimmed counts and three passes of
// the shared serial divider. A move in an accel or decel phase runs a serial
// multiply and one divider pass; a shutter-axis move skips the clamp state.
// The user must write registers only while no word is in flight; the block
// does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module interval_move_profile_planner_core
    import impp_pkg::*;
(
    input  wire                  aclk,
    input  wire                  aresetn,
    // register write port
    input  wire                  cfg_wr_en,
    input  wire [CFG_IDX_W-1:0]  cfg_index,
    input  wire [CFG_DATA_W-1:0] cfg_wr_data,
    // request words
    input  wire                  s_valid,
    output logic                 s_ready,
    input  wire in_word_t        s_data,
    // result words
    output logic                 m_valid,
    input  wire                  m_ready,
    output out_word_t            m_data
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TRIM,
        ST_TFIX,
        ST_PREP,
        ST_DIV_R,
        ST_MUL_A,
        ST_DIV_A,
        ST_DIV_D,
        ST_MOVE,
        ST_MUL,
        ST_DIV_M,
        ST_CLAMP,
        ST_DONE
    } state_t;

    localparam int RATE_W  = 41;   // |run| * 1000 fits here
    localparam int STEP_W  = 48;   // exact signed move before clamping
    localparam int QMOVE_W = 47;   // magnitude of a ramp move
    localparam int QRUN_W  = 34;   // magnitude of 2*travel / div

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [COUNT_W-1:0]      image_count_reg;
    logic [COUNT_W-1:0]      leadin_count_reg;
    logic [COUNT_W-1:0]      accel_count_reg;
    logic [COUNT_W-1:0]      decel_count_reg;
    logic [COUNT_W-1:0]      leadout_count_reg;
    logic signed [POS_W-1:0] start_pos_reg;
    logic signed [POS_W-1:0] end_pos_reg;
    logic                    shutter_axis_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_count_reg   <= COUNT_W'(1);
            leadin_count_reg  <= '0;
            accel_count_reg   <= COUNT_W'(1);
            decel_count_reg   <= COUNT_W'(1);
            leadout_count_reg <= '0;
            start_pos_reg     <= '0;
            end_pos_reg       <= '0;
            shutter_axis_reg  <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_IMAGE_COUNT:   image_count_reg   <= cfg_wr_data[COUNT_W-1:0];
                CFG_LEADIN_COUNT:  leadin_count_reg  <= cfg_wr_data[COUNT_W-1:0];
                CFG_ACCEL_COUNT:   accel_count_reg   <= cfg_wr_data[COUNT_W-1:0];
                CFG_DECEL_COUNT:   decel_count_reg   <= cfg_wr_data[COUNT_W-1:0];
                CFG_LEADOUT_COUNT: leadout_count_reg <= cfg_wr_data[COUNT_W-1:0];
                CFG_START_POS:     start_pos_reg     <= cfg_wr_data;
                CFG_END_POS:       end_pos_reg       <= cfg_wr_data;
                CFG_SHUTTER_AXIS:  shutter_axis_reg  <= cfg_wr_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // state and datapath registers
    // ------------------------------------------------------------------
    state_t state_reg, state_next;

    // trim search
    logic [18:0]        exc_reg, exc_next;
    logic [15:0]        k_reg, k_next;
    logic [3:0]         bit_reg, bit_next;

    // plan results (cleared by reset, a move before any plan sees zero rates)
    logic [COUNT_W-1:0] eff_leadin_reg, eff_leadin_next;
    logic [COUNT_W-1:0] eff_leadout_reg, eff_leadout_next;
    logic [COUNT_W-1:0] eff_accel_reg, eff_accel_next;
    logic [COUNT_W-1:0] eff_decel_reg, eff_decel_next;
    logic signed [POS_W-1:0] run_reg, run_next;
    logic [RATE_W-1:0]  amag_reg, amag_next;
    logic [RATE_W-1:0]  dmag_reg, dmag_next;

    logic               r_neg_reg, r_neg_next;
    logic [POS_W-1:0]   rmag_reg, rmag_next;

    // move request
    logic [COUNT_W-1:0]      cs_reg, cs_next;
    logic signed [POS_W-1:0] cur_reg, cur_next;

    // serial multiplier
    logic [DIV_NUM_W-1:0] mul_acc_reg, mul_acc_next;
    logic [15:0]          mul_k_reg, mul_k_next;
    logic [RATE_W-1:0]    mul_mag_reg, mul_mag_next;

    logic signed [STEP_W-1:0] steps_reg, steps_next;

    // result waiting for the output stage
    logic signed [POS_W-1:0] res_steps_reg, res_steps_next;
    logic [PHASE_W-1:0]      res_phase_reg, res_phase_next;
    logic                    res_cut_reg, res_cut_next;

    // output stage
    logic      m_valid_reg, m_valid_next;
    out_word_t m_data_reg, m_data_next;

    // shared divider
    logic                 div_go;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [DIV_NUM_W-1:0] div_quot;

    impp_div #(
        .NUM_W (DIV_NUM_W),
        .DEN_W (DIV_DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .go      (div_go),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot)
    );

    // ------------------------------------------------------------------
    // trimming: the round-robin decrement is solved as water filling.
    // after k full rounds each count has lost min(reducible, k); the
    // largest k that does not overshoot the excess is found one bit per
    // cycle, and the leftover goes one each to the first counts in order
    // slot order: lead-in, lead-out, accel, decel
    // ------------------------------------------------------------------
    logic [3:0][15:0] base_cnt;
    logic [3:0][15:0] red_cnt;
    logic [15:0]      accel_base, decel_base;
    logic [17:0]      base_sum;
    logic signed [18:0] gaps_s, sum_s;
    logic [18:0]      excess;

    function automatic logic [17:0] cut_sum(input logic [3:0][15:0] r, input logic [15:0] k);
        logic [17:0] s;
        s = '0;
        for (int i = 0; i < 4; i++) begin
            s = s + {2'b0, ((r[i] < k) ? r[i] : k)};
        end
        return s;
    endfunction

    always_comb begin
        accel_base  = (accel_count_reg == '0) ? 16'd1 : accel_count_reg;
        decel_base  = (decel_count_reg == '0) ? 16'd1 : decel_count_reg;
        base_cnt[0] = leadin_count_reg;
        base_cnt[1] = leadout_count_reg;
        base_cnt[2] = accel_base;
        base_cnt[3] = decel_base;
        red_cnt[0]  = leadin_count_reg;
        red_cnt[1]  = leadout_count_reg;
        red_cnt[2]  = accel_base - 16'd1;
        red_cnt[3]  = decel_base - 16'd1;
        base_sum    = {2'b0, base_cnt[0]} + {2'b0, base_cnt[1]}
                    + {2'b0, base_cnt[2]} + {2'b0, base_cnt[3]};
        // image count of zero gives a gap count of minus one
        gaps_s      = $signed({3'b0, image_count_reg}) - 19'sd1;
        sum_s       = $signed({1'b0, base_sum});
        excess      = (sum_s > gaps_s) ? 19'(sum_s - gaps_s) : '0;
    end

    logic [15:0] trial_k;
    logic [17:0] trial_sum;

    assign trial_k   = k_reg | (16'd1 << bit_reg);
    assign trial_sum = cut_sum(red_cnt, trial_k);

    logic [17:0]      fix_k_sum;
    logic [18:0]      fix_left;
    logic [2:0]       fix_rank;
    logic [3:0][15:0] fix_taken;
    logic [3:0]       fix_extra;
    logic [3:0][15:0] eff_fix;

    always_comb begin
        fix_k_sum = cut_sum(red_cnt, k_reg);
        fix_left  = exc_reg - {1'b0, fix_k_sum};
        fix_rank  = '0;
        for (int i = 0; i < 4; i++) begin
            fix_taken[i] = (red_cnt[i] < k_reg) ? red_cnt[i] : k_reg;
            fix_extra[i] = (red_cnt[i] > k_reg) && ({16'b0, fix_rank} < fix_left);
            eff_fix[i]   = base_cnt[i] - fix_taken[i] - {15'b0, fix_extra[i]};
            fix_rank     = fix_rank + {2'b0, (red_cnt[i] > k_reg)};
        end
    end

    // ------------------------------------------------------------------
    // plan set-up from the trimmed counts
    // ------------------------------------------------------------------
    logic [16:0]        lead_sum, ramp_sum;
    logic signed [18:0] movable;
    logic signed [19:0] divisor_s;
    logic signed [32:0] travel;
    logic [32:0]        dist_mag;
    logic               plan_go;
    logic [41:0]        rmag_milli;

    always_comb begin
        lead_sum   = {1'b0, eff_leadin_reg} + {1'b0, eff_leadout_reg};
        ramp_sum   = {1'b0, eff_accel_reg} + {1'b0, eff_decel_reg};
        movable    = gaps_s - $signed({2'b0, lead_sum});
        // 2*run + ramp with run = movable - ramp
        divisor_s  = $signed({movable, 1'b0}) - $signed({3'b0, ramp_sum});
        travel     = $signed({end_pos_reg[POS_W-1], end_pos_reg})
                   - $signed({start_pos_reg[POS_W-1], start_pos_reg});
        dist_mag   = travel[32] ? 33'(-travel) : 33'(travel);
        plan_go    = (movable > 19'sd0) && (end_pos_reg != start_pos_reg)
                   && (divisor_s > 20'sd0);
        // |run| * 1000 as 1024 - 16 - 8
        rmag_milli = {rmag_reg, 10'b0} - {6'b0, rmag_reg, 4'b0} - {7'b0, rmag_reg, 3'b0};
    end

    // ------------------------------------------------------------------
    // move phase decision
    // ------------------------------------------------------------------
    logic signed [18:0] cs_s, n_s, el_s, ea_s, ed_s, eo_s;
    logic signed [18:0] thr_lead, thr_accel, thr_run, thr_decel;
    logic signed [18:0] acc_off, dec_off;

    always_comb begin
        cs_s      = $signed({3'b0, cs_reg});
        n_s       = $signed({3'b0, image_count_reg});
        el_s      = $signed({3'b0, eff_leadin_reg});
        ea_s      = $signed({3'b0, eff_accel_reg});
        ed_s      = $signed({3'b0, eff_decel_reg});
        eo_s      = $signed({3'b0, eff_leadout_reg});
        thr_lead  = el_s + 19'sd1;
        thr_accel = el_s + ea_s;
        thr_run   = n_s - ed_s - eo_s + 19'sd1;
        thr_decel = n_s - eo_s;
        acc_off   = cs_s - el_s;
        dec_off   = thr_decel - cs_s;
    end

    // room left to the end position, and the clamp test
    logic signed [32:0] room;
    logic signed [48:0] pos_sum;
    logic signed [48:0] end_wide;
    logic               heading_up;
    logic               overshoot;
    logic [DIV_NUM_W-1:0] mul_acc_step;
    logic [QMOVE_W-1:0] q_move;
    logic [QRUN_W-1:0]  q_run;

    always_comb begin
        room         = $signed({end_pos_reg[POS_W-1], end_pos_reg})
                     - $signed({cur_reg[POS_W-1], cur_reg});
        pos_sum      = $signed({{17{cur_reg[POS_W-1]}}, cur_reg})
                     + $signed({steps_reg[STEP_W-1], steps_reg});
        end_wide     = $signed({{17{end_pos_reg[POS_W-1]}}, end_pos_reg});
        heading_up   = !travel[32];
        overshoot    = heading_up ? (pos_sum > end_wide) : (pos_sum < end_wide);
        mul_acc_step = {mul_acc_reg[DIV_NUM_W-2:0], 1'b0}
                     + (mul_k_reg[15] ? DIV_NUM_W'(mul_mag_reg) : '0);
        q_move       = div_quot[QMOVE_W-1:0];
        q_run        = div_quot[QRUN_W-1:0];
    end

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next       = state_reg;
        exc_next         = exc_reg;
        k_next           = k_reg;
        bit_next         = bit_reg;
        eff_leadin_next  = eff_leadin_reg;
        eff_leadout_next = eff_leadout_reg;
        eff_accel_next   = eff_accel_reg;
        eff_decel_next   = eff_decel_reg;
        run_next         = run_reg;
        amag_next        = amag_reg;
        dmag_next        = dmag_reg;
        r_neg_next       = r_neg_reg;
        rmag_next        = rmag_reg;
        cs_next          = cs_reg;
        cur_next         = cur_reg;
        mul_acc_next     = mul_acc_reg;
        mul_k_next       = mul_k_reg;
        mul_mag_next     = mul_mag_reg;
        steps_next       = steps_reg;
        res_steps_next   = res_steps_reg;
        res_phase_next   = res_phase_reg;
        res_cut_next     = res_cut_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        div_go           = 1'b0;
        div_num          = '0;
        div_den          = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.req_type == REQ_PLAN) begin
                        exc_next   = excess;
                        k_next     = '0;
                        bit_next   = 4'd15;
                        state_next = ST_TRIM;
                    end else begin
                        cs_next    = s_data.step_index;
                        cur_next   = s_data.current_position;
                        state_next = ST_MOVE;
                    end
                end
            end

            // one bit of the round count per cycle, msb first
            ST_TRIM: begin
                if (trial_sum <= exc_reg[17:0] || exc_reg[18]) begin
                    k_next = trial_k;
                end
                if (bit_reg == 4'd0) begin
                    state_next = ST_TFIX;
                end else begin
                    bit_next = bit_reg - 4'd1;
                end
            end

            ST_TFIX: begin
                eff_leadin_next  = eff_fix[0];
                eff_leadout_next = eff_fix[1];
                eff_accel_next   = eff_fix[2];
                eff_decel_next   = eff_fix[3];
                state_next       = ST_PREP;
            end

            ST_PREP: begin
                if (plan_go) begin
                    div_go     = 1'b1;
                    div_num    = DIV_NUM_W'({dist_mag, 1'b0});
                    div_den    = divisor_s[DIV_DEN_W-1:0];
                    r_neg_next = travel[32];
                    state_next = ST_DIV_R;
                end else begin
                    // no room or no distance: all rates zero
                    run_next       = '0;
                    amag_next      = '0;
                    dmag_next      = '0;
                    res_steps_next = '0;
                    res_phase_next = PH_PLAN;
                    res_cut_next   = 1'b0;
                    state_next     = ST_DONE;
                end
            end

            // run rate, saturated to the signed 32-bit range
            ST_DIV_R: begin
                if (div_done) begin
                    if (r_neg_reg) begin
                        rmag_next = (q_run > QRUN_W'(33'h080000000)) ? 32'h80000000
                                                                     : q_run[POS_W-1:0];
                        run_next  = (q_run > QRUN_W'(33'h080000000)) ? 32'sh80000000
                                                                     : -$signed(q_run[POS_W-1:0]);
                    end else begin
                        rmag_next = (q_run > QRUN_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF
                                                                    : q_run[POS_W-1:0];
                        run_next  = (q_run > QRUN_W'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                                    : $signed(q_run[POS_W-1:0]);
                    end
                    state_next = ST_MUL_A;
                end
            end

            ST_MUL_A: begin
                div_go     = 1'b1;
                div_num    = DIV_NUM_W'(rmag_milli[RATE_W-1:0]);
                div_den    = DIV_DEN_W'(eff_accel_reg);
                state_next = ST_DIV_A;
            end

            ST_DIV_A: begin
                if (div_done) begin
                    amag_next  = div_quot[RATE_W-1:0];
                    div_go     = 1'b1;
                    div_num    = DIV_NUM_W'(rmag_milli[RATE_W-1:0]);
                    div_den    = DIV_DEN_W'(eff_decel_reg);
                    state_next = ST_DIV_D;
                end
            end

            ST_DIV_D: begin
                if (div_done) begin
                    dmag_next      = div_quot[RATE_W-1:0];
                    res_steps_next = '0;
                    res_phase_next = PH_PLAN;
                    res_cut_next   = 1'b0;
                    state_next     = ST_DONE;
                end
            end

            ST_MOVE: begin
                if (shutter_axis_reg) begin
                    res_steps_next = room[POS_W-1:0];
                    res_phase_next = PH_SHUTTER;
                    res_cut_next   = 1'b0;
                    state_next     = ST_DONE;
                end else if (cs_s < thr_lead) begin
                    steps_next     = '0;
                    res_phase_next = PH_LEADIN;
                    state_next     = ST_CLAMP;
                end else if (cs_s < thr_accel) begin
                    mul_acc_next   = '0;
                    mul_k_next     = acc_off[15:0];
                    mul_mag_next   = amag_reg;
                    bit_next       = 4'd15;
                    res_phase_next = PH_ACCEL;
                    state_next     = ST_MUL;
                end else if (cs_s < thr_run) begin
                    steps_next     = STEP_W'(run_reg);
                    res_phase_next = PH_RUN;
                    state_next     = ST_CLAMP;
                end else if (cs_s < thr_decel) begin
                    mul_acc_next   = '0;
                    mul_k_next     = dec_off[15:0];
                    mul_mag_next   = dmag_reg;
                    bit_next       = 4'd15;
                    res_phase_next = PH_DECEL;
                    state_next     = ST_MUL;
                end else begin
                    steps_next     = '0;
                    res_phase_next = PH_LEADOUT;
                    state_next     = ST_CLAMP;
                end
            end

            // rate magnitude times frame offset, one multiplier bit per cycle
            ST_MUL: begin
                mul_acc_next = mul_acc_step;
                mul_k_next   = {mul_k_reg[14:0], 1'b0};
                if (bit_reg == 4'd0) begin
                    div_go     = 1'b1;
                    div_num    = mul_acc_step;
                    div_den    = DIV_DEN_W'(MILLI);
                    state_next = ST_DIV_M;
                end else begin
                    bit_next = bit_reg - 4'd1;
                end
            end

            // the rate carries the sign of the run rate
            ST_DIV_M: begin
                if (div_done) begin
                    steps_next = run_reg[POS_W-1] ? -$signed({1'b0, q_move})
                                                  : $signed({1'b0, q_move});
                    state_next = ST_CLAMP;
                end
            end

            // never pass the end position
            ST_CLAMP: begin
                res_cut_next   = overshoot;
                res_steps_next = overshoot ? room[POS_W-1:0] : steps_reg[POS_W-1:0];
                state_next     = ST_DONE;
            end

            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.move_steps = res_steps_reg;
                    m_data_next.phase      = res_phase_reg;
                    m_data_next.clamped    = res_cut_reg;
                    state_next             = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            eff_leadin_reg  <= '0;
            eff_leadout_reg <= '0;
            eff_accel_reg   <= '0;
            eff_decel_reg   <= '0;
            run_reg         <= '0;
            amag_reg        <= '0;
            dmag_reg        <= '0;
        end else begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            eff_leadin_reg  <= eff_leadin_next;
            eff_leadout_reg <= eff_leadout_next;
            eff_accel_reg   <= eff_accel_next;
            eff_decel_reg   <= eff_decel_next;
            run_reg         <= run_next;
            amag_reg        <= amag_next;
            dmag_reg        <= dmag_next;
            exc_reg         <= exc_next;
            k_reg           <= k_next;
            bit_reg         <= bit_next;
            r_neg_reg       <= r_neg_next;
            rmag_reg        <= rmag_next;
            cs_reg          <= cs_next;
            cur_reg         <= cur_next;
            mul_acc_reg     <= mul_acc_next;
            mul_k_reg       <= mul_k_next;
            mul_mag_reg     <= mul_mag_next;
            steps_reg       <= steps_next;
            res_steps_reg   <= res_steps_next;
            res_phase_reg   <= res_phase_next;
            res_cut_reg     <= res_cut_next;
            m_data_reg      <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire
